// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the mode controller.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/icmc_pkg.sv =====
// Package of the intermittent compression mode controller.
// Holds event codes, register indexes, controller commands and sizes.
package icmc_pkg;

    localparam int HistoryLenDef = 12;
    localparam int ThetaDef      = 37;
    localparam int CountWidthDef = 32;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int ThrW     = 32;
    localparam int SumW     = 15;

    localparam logic [1:0] EV_MEMOPS = 2'd0;
    localparam logic [1:0] EV_EVICT  = 2'd1;
    localparam logic [1:0] EV_PWROFF = 2'd2;
    localparam logic [1:0] EV_REBOOT = 2'd3;

    localparam logic [CfgIdxW-1:0] REG_INIT_THR   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CONF_INIT  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CLOSE_FRAC = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_AIMD_EN    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_CAP_FRAC   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_CONF_MIN   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_PRED_EN    = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_PRED_VOL   = 3'd7;

    // Commands from the controller to the datapath, one per cycle.
    typedef struct packed {
        logic load;     // capture the accepted transaction, do phase one
        logic phase2;   // commit the event (phase two)
        logic walk;     // one step of the perceptron walk
        logic walk_init;
        logic done;     // result register loaded
    } t_cmd;

    typedef struct packed {
        logic walk_last;
        logic need_walk;
    } t_status;

endpackage

// ===== hw/rtl/intermittent_compression_mode_controller.sv =====
// Intermittent compression mode controller. Each transaction is one event and
// gives one result. Memory-op and eviction events, a first power off, and power-off
// and reboot events while the perceptron is disabled take the load and phase-two
// steps only; a later power off and a reboot with the perceptron enabled then walk
// the HISTORY_LEN+1 weights, one weight per cycle. Depends on icmc_pkg, icmc_ctrl
// and icmc_dp.
module intermittent_compression_mode_controller #(
    parameter int HISTORY_LEN = icmc_pkg::HistoryLenDef,
    parameter int THETA       = icmc_pkg::ThetaDef,
    parameter int COUNT_WIDTH = icmc_pkg::CountWidthDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [icmc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [icmc_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic [3:0]                    i_op_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_regular_active,
    output logic                          o_mode_changed,
    output logic                          o_gate_vetoed,
    output logic [icmc_pkg::ThrW-1:0]     o_threshold_now,
    output logic [1:0]                    o_confidence_now,
    output logic signed [icmc_pkg::SumW-1:0] o_predictor_out
);
    import icmc_pkg::*;

    t_cmd    cmd;
    t_status status;

    icmc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_status(status), .o_cmd(cmd)
    );

    icmc_dp #(
        .HISTORY_LEN(HISTORY_LEN), .THETA(THETA), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_mode, .i_op_count, .i_cmd(cmd), .o_status(status),
        .o_regular_active, .o_mode_changed, .o_gate_vetoed,
        .o_threshold_now, .o_confidence_now, .o_predictor_out
    );
endmodule

// ===== hw/rtl/icmc_ctrl.sv =====
// Controller state machine of the mode controller.
// Depends on icmc_pkg and assert_macros.svh.
module icmc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  icmc_pkg::t_status i_status,
    output icmc_pkg::t_cmd    o_cmd
);
    import icmc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PH2  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       accept, fin;

    // Accept only when idle and the result slot is free or draining.
    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_ovalid;

    // Sequence through the event phases.
    always_comb begin
        n_state = r_state;
        fin     = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PH2;
                end
            end
            S_PH2: begin
                o_cmd.phase2 = 1'b1;
                if (i_status.need_walk) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = S_WALK;
                end else begin
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_last) begin
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.done = fin;
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        if (fin) n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `ASSERT_NEXT(a_load_ph2, i_clk, i_rst_n, accept, r_state == S_PH2)
    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, fin, r_ovalid)
endmodule

// ===== hw/rtl/icmc_dp.sv =====
// Datapath of the mode controller: counters, threshold, confidence, perceptron.
// Depends on icmc_pkg and assert_macros.svh.
module icmc_dp #(
    parameter int HISTORY_LEN = icmc_pkg::HistoryLenDef,
    parameter int THETA       = icmc_pkg::ThetaDef,
    parameter int COUNT_WIDTH = icmc_pkg::CountWidthDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [icmc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [icmc_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic [1:0]                    i_mode,
    input  logic [3:0]                    i_op_count,
    input  icmc_pkg::t_cmd                i_cmd,
    output icmc_pkg::t_status             o_status,
    output logic                          o_regular_active,
    output logic                          o_mode_changed,
    output logic                          o_gate_vetoed,
    output logic [icmc_pkg::ThrW-1:0]     o_threshold_now,
    output logic [1:0]                    o_confidence_now,
    output logic signed [icmc_pkg::SumW-1:0] o_predictor_out
);
    import icmc_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int HW = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN + 1) : 1;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    // Reciprocal of ten: ceil(2^(CW+3)/10) gives an exact quotient for every CW-bit value.
    localparam logic [CW+3:0] RECIP_FULL =
        ({1'b1, {(CW+3){1'b0}}} + (CW+4)'(9)) / (CW+4)'(10);
    localparam logic [CW-1:0] RECIP10 = RECIP_FULL[CW-1:0];

    // Configuration registers.
    logic [31:0] r_init_thr;
    logic [1:0]  r_conf_init, r_conf_min;
    logic [7:0]  r_close_frac, r_cap_frac;
    logic        r_aimd_en, r_pred_en, r_pred_vol;

    // State.
    logic [CW-1:0]        r_mem, r_prev, r_thr, r_evict;
    logic signed [CW:0]   r_adj;
    logic [1:0]           r_conf;
    logic                 r_reg, r_hval, r_gate;
    logic signed [7:0]    r_w [HISTORY_LEN+1];
    logic signed [1:0]    r_hist [HISTORY_LEN];
    logic signed [SumW-1:0] r_sum;

    // Event scratch.
    logic [1:0]           r_ev;
    logic [3:0]           r_ops;
    logic                 r_changed;
    logic                 r_close;     // power off: estimate close
    logic                 r_train;     // power off: weights update
    logic [HW-1:0]        r_widx;
    logic signed [SumW-1:0] r_acc;
    logic [CW+7:0]        r_prod;      // frac * value product
    logic [CW-1:0]        r_err;
    logic                 r_pof_go;
    logic [CW-1:0]        r_thr_tenth; // threshold / 10, captured with the transaction
    logic [2*CW-1:0]      tenth_prod;

    // Output register.
    logic                 r_o_reg, r_o_chg, r_o_gate;
    logic [ThrW-1:0]      r_o_thr;
    logic [1:0]           r_o_conf;
    logic signed [SumW-1:0] r_o_sum;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? CMAX : s[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] load_thr(input logic [31:0] v);
        logic [CW-1:0] t;
        if (v == 32'd0) t = CW'(1);
        else if (CW < 32 && (v >> CW) != 32'd0) t = CMAX;
        else t = CW'(v);
        return t;
    endfunction

    // Phase-one combinational values.
    logic [CW-1:0]      mem_new;
    logic signed [CW+1:0] diff;
    logic               hit, veto;
    logic signed [CW:0] adj_new;
    logic [CW-1:0]      err_abs;
    logic [CW-1:0]      prev_mc;
    logic [CW-1:0]      thr_half, thr_tenth, thr_step;
    logic [CW-1:0]      thr_aimd;
    logic [CW+7:0]      prod_src;

    assign mem_new = sat_add(r_mem, CW'(r_ops));
    assign diff    = $signed({2'b00, r_prev}) - $signed({2'b00, mem_new});
    assign hit     = diff <= $signed({2'b00, r_thr});
    assign veto    = (r_pred_en && r_sum < 0) ||
                     (r_conf_min != 2'd0 && r_conf < r_conf_min);
    assign adj_new = $signed({1'b0, r_mem}) - $signed({1'b0, r_prev});
    assign err_abs = adj_new < 0 ? CW'(-adj_new) : CW'(adj_new);

    // Rebuilt estimate at reboot.
    always_comb begin
        prev_mc = r_mem;
        if (r_conf <= 2'd1) begin
            if (r_adj < 0) begin
                prev_mc = ($unsigned(-r_adj) >= {1'b0, r_mem}) ? '0 :
                          r_mem - CW'($unsigned(-r_adj));
            end else begin
                prev_mc = (r_adj[CW] || r_adj[CW-1:0] > CMAX - r_mem) ? CMAX :
                          r_mem + r_adj[CW-1:0];
            end
        end
    end

    // Division by ten by reciprocal multiplication, registered at load.
    assign tenth_prod = (2*CW)'(r_thr) * (2*CW)'(RECIP10);

    assign thr_half  = r_thr >> 1;
    assign thr_tenth = r_thr_tenth;
    assign thr_step  = (thr_tenth == '0) ? CW'(1) : thr_tenth;
    assign thr_aimd  = (r_evict > thr_half) ?
                       ((thr_half == '0) ? CW'(1) : thr_half) : sat_add(r_thr, thr_step);

    // One shared frac * value product, registered before its compare.
    assign prod_src = (i_mode == EV_PWROFF) ? ({8'd0, r_prev} * {{CW{1'b0}}, r_close_frac})
                                            : ({8'd0, prev_mc} * {{CW{1'b0}}, r_cap_frac});

    logic [CW-1:0] frac_res, cap;
    logic          close_c, train_c;
    logic signed [SumW-1:0] mag;
    assign frac_res = r_prod[CW+7:8];
    assign close_c  = r_err <= frac_res;
    assign cap      = (frac_res == '0) ? CW'(1) : frac_res;
    assign mag      = (r_sum < 0) ? -r_sum : r_sum;
    assign train_c  = ((r_sum >= 0) != close_c) || (mag <= SumW'(THETA));

    // Next threshold at reboot and next confidence at power off.
    logic [CW-1:0] thr_new;
    logic [1:0]    conf_new;
    assign thr_new  = (r_cap_frac != 8'd0 && thr_aimd > cap) ? cap : thr_aimd;
    assign conf_new = close_c ? ((r_conf != 2'd3) ? r_conf + 2'd1 : r_conf)
                              : ((r_conf != 2'd0) ? r_conf - 2'd1 : r_conf);

    logic last;
    assign last = (r_widx == HW'(HISTORY_LEN));
    assign o_status.walk_last = last;
    assign o_status.need_walk = r_pred_en && ((r_ev == EV_PWROFF && r_pof_go) ||
                                              r_ev == EV_REBOOT);

    // Weight step for index r_widx during the walk.
    logic signed [8:0] w_cur, w_inc;
    logic signed [1:0] h_cur;
    always_comb begin
        h_cur = (r_widx == '0) ? 2'sd1 : r_hist[r_widx - HW'(1)];
        w_cur = 9'(r_w[r_widx]);
        if (r_close) w_inc = w_cur + 9'(h_cur);
        else         w_inc = w_cur - 9'(h_cur);
        if (w_inc > 9'sd127) w_inc = 9'sd127;
        if (w_inc < -9'sd127) w_inc = -9'sd127;
    end

    logic signed [SumW-1:0] term;
    always_comb begin
        case (h_cur)
            2'sd1:   term = SumW'(r_w[r_widx]);
            -2'sd1:  term = -SumW'(r_w[r_widx]);
            default: term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_thr   <= 32'd16;
            r_conf_init  <= 2'd2;
            r_close_frac <= 8'd26;
            r_aimd_en    <= 1'b1;
            r_cap_frac   <= 8'd0;
            r_conf_min   <= 2'd0;
            r_pred_en    <= 1'b0;
            r_pred_vol   <= 1'b0;
            r_mem   <= '0;
            r_prev  <= '0;
            r_thr   <= load_thr(32'd16);
            r_evict <= '0;
            r_adj   <= '0;
            r_conf  <= 2'd2;
            r_reg   <= 1'b0;
            r_hval  <= 1'b0;
            r_gate  <= 1'b0;
            r_sum   <= '0;
            for (int i = 0; i <= HISTORY_LEN; i++) r_w[i] <= '0;
            for (int i = 0; i < HISTORY_LEN; i++) r_hist[i] <= '0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INIT_THR: begin
                        r_init_thr <= i_cfg_data;
                        r_thr      <= load_thr(i_cfg_data);
                    end
                    REG_CONF_INIT: begin
                        r_conf_init <= i_cfg_data[1:0];
                        r_conf      <= i_cfg_data[1:0];
                    end
                    REG_CLOSE_FRAC: r_close_frac <= i_cfg_data[7:0];
                    REG_AIMD_EN:    r_aimd_en    <= i_cfg_data[0];
                    REG_CAP_FRAC:   r_cap_frac   <= i_cfg_data[7:0];
                    REG_CONF_MIN:   r_conf_min   <= i_cfg_data[1:0];
                    REG_PRED_EN:    r_pred_en    <= i_cfg_data[0];
                    REG_PRED_VOL:   r_pred_vol   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // Phase two: commit the event.
            if (i_cmd.phase2) begin
                case (r_ev)
                    EV_MEMOPS: begin
                        r_mem <= mem_new;
                        if (!r_reg && r_hval && !r_gate && hit) begin
                            if (veto) r_gate <= 1'b1;
                            else      r_reg  <= 1'b1;
                        end
                    end
                    EV_EVICT: if (r_reg) r_evict <= sat_add(r_evict, CW'(1));
                    EV_PWROFF: begin
                        if (!r_hval) begin
                            r_adj  <= '0;
                            r_hval <= 1'b1;
                        end else begin
                            r_adj  <= adj_new;
                            r_conf <= conf_new;
                        end
                    end
                    default: begin
                        r_prev  <= prev_mc;
                        r_mem   <= '0;
                        r_evict <= '0;
                        r_gate  <= 1'b0;
                        r_reg   <= 1'b0;
                        if (r_aimd_en && !r_gate) r_thr <= thr_new;
                        if (r_pred_en && r_pred_vol) begin
                            for (int i = 0; i <= HISTORY_LEN; i++) r_w[i] <= '0;
                            for (int i = 0; i < HISTORY_LEN; i++) r_hist[i] <= '0;
                        end
                    end
                endcase
            end
            // Perceptron walk: training at power off, sum at reboot.
            if (i_cmd.walk) begin
                if (r_ev == EV_PWROFF) begin
                    if (r_train) r_w[r_widx] <= 8'(w_inc);
                    if (last) begin
                        for (int i = HISTORY_LEN - 1; i > 0; i--) r_hist[i] <= r_hist[i-1];
                        r_hist[0] <= r_close ? 2'sd1 : -2'sd1;
                    end
                end else if (last) begin
                    r_sum <= r_acc + term;
                end
            end
        end
    end

    // Event scratch, walk and output registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ev        <= i_mode;
            r_ops       <= i_op_count;
            r_changed   <= 1'b0;
            r_err       <= err_abs;
            r_pof_go    <= r_hval;
            r_thr_tenth <= CW'(tenth_prod[2*CW-1:CW+3]);
        end
        // Product register feeds the phase-two compares.
        if (i_cmd.load) r_prod <= prod_src;
        if (i_cmd.phase2) begin
            r_close <= close_c;
            r_train <= train_c;
            r_changed <= (r_ev == EV_MEMOPS) ?
                         (!r_reg && r_hval && !r_gate && hit && !veto) :
                         (r_ev == EV_REBOOT) ? r_reg : 1'b0;
        end
        if (i_cmd.walk_init) begin
            r_widx <= '0;
            r_acc  <= '0;
        end else if (i_cmd.walk) begin
            r_widx <= r_widx + HW'(1);
            r_acc  <= r_acc + term;
        end
        if (i_cmd.done) begin
            r_o_reg  <= (i_cmd.phase2 && r_ev == EV_MEMOPS) ?
                        (r_reg || (!r_reg && r_hval && !r_gate && hit && !veto)) :
                        (i_cmd.phase2 && r_ev == EV_REBOOT) ? 1'b0 : r_reg;
            r_o_chg  <= i_cmd.phase2 ? ((r_ev == EV_MEMOPS) ?
                        (!r_reg && r_hval && !r_gate && hit && !veto) :
                        (r_ev == EV_REBOOT) ? r_reg : 1'b0) : r_changed;
            r_o_gate <= (i_cmd.phase2 && r_ev == EV_MEMOPS) ?
                        (r_gate || (!r_reg && r_hval && hit && veto)) :
                        (i_cmd.phase2 && r_ev == EV_REBOOT) ? 1'b0 : r_gate;
            r_o_thr  <= (i_cmd.phase2 && r_ev == EV_REBOOT && r_aimd_en && !r_gate) ?
                        ThrW'(thr_new) : ThrW'(r_thr);
            r_o_conf <= (i_cmd.phase2 && r_ev == EV_PWROFF && r_hval) ? conf_new : r_conf;
            r_o_sum  <= (i_cmd.walk && r_ev == EV_REBOOT) ? r_acc + term : r_sum;
        end
    end

    assign o_regular_active = r_o_reg;
    assign o_mode_changed   = r_o_chg;
    assign o_gate_vetoed    = r_o_gate;
    assign o_threshold_now  = r_o_thr;
    assign o_confidence_now = r_o_conf;
    assign o_predictor_out  = r_o_sum;

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_widx_range, i_clk, i_rst_n, i_cmd.walk, r_widx <= HW'(HISTORY_LEN))
    `ASSERT_IMPL(a_thr_nonzero, i_clk, i_rst_n, 1'b1, r_thr != '0)
    `ASSERT_IMPL(a_reg_needs_hist, i_clk, i_rst_n, r_reg, r_hval)
endmodule

// ===== tb/sv/intermittent_compression_mode_controller_tb.sv =====
// Self-checking testbench of the intermittent compression mode controller.
// Drives power-cycle event sequences and checks every result against a shadow model or typed row.
// Depends on icmc_pkg and intermittent_compression_mode_controller.
`timescale 1ns / 1ps

module intermittent_compression_mode_controller_tb;
    import icmc_pkg::*;

    localparam longint CountMax = 64'hFFFF_FFFF;
    localparam int     HistLen  = HistoryLenDef;
    localparam int     Theta    = ThetaDef;

    typedef struct {
        logic              regular;
        logic              changed;
        logic              gate;
        logic [ThrW-1:0]   thr;
        logic [1:0]        conf;
        logic [SumW-1:0]   psum;
    } t_status_out;

    typedef struct {
        logic [1:0]  mode;
        logic [3:0]  ops;
        bit          typed;
        t_status_out want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [1:0]        i_mode = EV_MEMOPS;
    logic [3:0]        i_op_count = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_regular_active;
    logic              o_mode_changed;
    logic              o_gate_vetoed;
    logic [ThrW-1:0]   o_threshold_now;
    logic [1:0]        o_confidence_now;
    logic signed [SumW-1:0] o_predictor_out;

    intermittent_compression_mode_controller uut (.*);

    always #10 i_clk = ~i_clk;

    // Shadow configuration of the controller.
    longint unsigned cfg_init_thr, cfg_conf_init, cfg_close_frac, cfg_aimd;
    longint unsigned cfg_cap_frac, cfg_conf_min, cfg_pred_en, cfg_pred_vol;

    // Shadow state of the controller.
    longint unsigned sh_mem, sh_prev, sh_thr, sh_evict;
    longint          sh_adjust;
    int              sh_conf;
    bit              sh_regular, sh_hist_valid, sh_gate;
    int              sh_weight [HistLen+1];
    int              sh_outcome [HistLen];
    int              sh_psum;

    t_status_out pending_results [$];
    int          errors = 0;
    int          results_seen = 0;
    int          entries_seen = 0;
    int          vetoes_seen = 0;
    int          items_sent = 0;
    bit          hold_request = 1'b0;
    int          burst_left = 0;

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        if (a >= CountMax || b > CountMax - a) return CountMax;
        return a + b;
    endfunction

    function automatic longint unsigned q8_part(longint unsigned frac, longint unsigned v);
        return frac * (v >> 8) + ((frac * (v & 255)) >> 8);
    endfunction

    function automatic int clip_weight(int w);
        if (w > 127) return 127;
        if (w < -127) return -127;
        return w;
    endfunction

    function automatic longint unsigned thr_load(longint unsigned v);
        if (v == 0) v = 1;
        if (v > CountMax) v = CountMax;
        return v;
    endfunction

    task automatic model_reset();
        cfg_init_thr = 16; cfg_conf_init = 2; cfg_close_frac = 26; cfg_aimd = 1;
        cfg_cap_frac = 0; cfg_conf_min = 0; cfg_pred_en = 0; cfg_pred_vol = 0;
        sh_mem = 0; sh_prev = 0; sh_thr = thr_load(cfg_init_thr); sh_evict = 0;
        sh_adjust = 0; sh_conf = 2; sh_regular = 0; sh_hist_valid = 0; sh_gate = 0;
        foreach (sh_weight[i]) sh_weight[i] = 0;
        foreach (sh_outcome[i]) sh_outcome[i] = 0;
        sh_psum = 0;
    endtask

    // Score the estimate of the cycle that just ended and train the perceptron.
    task automatic score_power_off();
        longint unsigned err;
        bit close;
        int t, mag;
        if (!sh_hist_valid) begin
            sh_adjust = 0;
            sh_hist_valid = 1;
            return;
        end
        sh_adjust = longint'(sh_mem) - longint'(sh_prev);
        err = (sh_adjust < 0) ? longint'(-sh_adjust) : sh_adjust;
        close = err <= q8_part(cfg_close_frac, sh_prev);
        if (close) begin
            if (sh_conf < 3) sh_conf++;
        end else if (sh_conf > 0) begin
            sh_conf--;
        end
        if (cfg_pred_en != 0) begin
            t = close ? 1 : -1;
            mag = (sh_psum < 0) ? -sh_psum : sh_psum;
            if ((sh_psum >= 0) != close || mag <= Theta) begin
                sh_weight[0] = clip_weight(sh_weight[0] + t);
                for (int i = 0; i < HistLen; i++)
                    sh_weight[i+1] = clip_weight(sh_weight[i+1] + t * sh_outcome[i]);
            end
            for (int i = HistLen - 1; i > 0; i--) sh_outcome[i] = sh_outcome[i-1];
            sh_outcome[0] = t;
        end
    endtask

    // Rebuild the estimate, tune the threshold and recompute the perceptron sum.
    task automatic rebuild_on_reboot(output bit changed);
        longint unsigned neg, cap;
        changed = sh_regular;
        sh_prev = sh_mem;
        sh_mem = 0;
        if (sh_conf <= 1) begin
            if (sh_adjust < 0) begin
                neg = longint'(-sh_adjust);
                sh_prev = (neg >= sh_prev) ? 0 : sh_prev - neg;
            end else begin
                sh_prev = sat_sum(sh_prev, sh_adjust);
            end
        end
        if (cfg_aimd != 0 && !sh_gate) begin
            if (sh_evict > sh_thr / 2) begin
                sh_thr = sh_thr / 2;
                if (sh_thr == 0) sh_thr = 1;
            end else begin
                sh_thr = sat_sum(sh_thr, (sh_thr / 10 != 0) ? sh_thr / 10 : 1);
            end
            if (cfg_cap_frac != 0) begin
                cap = q8_part(cfg_cap_frac, sh_prev);
                if (cap == 0) cap = 1;
                if (sh_thr > cap) sh_thr = cap;
            end
        end
        sh_evict = 0;
        sh_gate = 0;
        if (cfg_pred_en != 0) begin
            if (cfg_pred_vol != 0) begin
                foreach (sh_weight[i]) sh_weight[i] = 0;
                foreach (sh_outcome[i]) sh_outcome[i] = 0;
            end
            sh_psum = sh_weight[0];
            for (int i = 0; i < HistLen; i++) sh_psum += sh_weight[i+1] * sh_outcome[i];
        end
        sh_regular = 0;
    endtask

    // Count memory operations and decide on entering regular mode.
    task automatic count_mem_ops(input longint unsigned n, output bit changed);
        bit veto;
        changed = 0;
        sh_mem = sat_sum(sh_mem, n);
        if (sh_regular || !sh_hist_valid || sh_gate) return;
        if (longint'(sh_prev) - longint'(sh_mem) <= longint'(sh_thr)) begin
            veto = (cfg_pred_en != 0 && sh_psum < 0) ||
                   (cfg_conf_min > 0 && sh_conf < cfg_conf_min);
            if (veto) begin
                sh_gate = 1;
                return;
            end
            sh_regular = 1;
            changed = 1;
        end
    endtask

    task automatic predict_event(input logic [1:0] mode, input logic [3:0] ops,
                                 output t_status_out res);
        bit changed;
        changed = 0;
        case (mode)
            EV_MEMOPS: count_mem_ops(ops, changed);
            EV_EVICT: begin
                if (sh_regular) sh_evict = sat_sum(sh_evict, 1);
            end
            EV_PWROFF: score_power_off();
            default: rebuild_on_reboot(changed);
        endcase
        res.regular = sh_regular;
        res.changed = changed;
        res.gate    = sh_gate;
        res.thr     = sh_thr[ThrW-1:0];
        res.conf    = sh_conf[1:0];
        res.psum    = sh_psum[SumW-1:0];
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("Mismatch at %0t on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Register write, mirrored into the shadow configuration.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_INIT_THR: begin
                cfg_init_thr = data;
                sh_thr = thr_load(cfg_init_thr);
            end
            REG_CONF_INIT: begin
                cfg_conf_init = data & 3;
                sh_conf = cfg_conf_init;
            end
            REG_CLOSE_FRAC: cfg_close_frac = data & 255;
            REG_AIMD_EN:    cfg_aimd = data & 1;
            REG_CAP_FRAC:   cfg_cap_frac = data & 255;
            REG_CONF_MIN:   cfg_conf_min = data & 3;
            REG_PRED_EN:    cfg_pred_en = data & 1;
            default:        cfg_pred_vol = data & 1;
        endcase
    endtask

    task automatic write_all_regs(logic [31:0] thr, int ci, int cf, int ae, int cap,
                                  int cm, int pe, int pv, bit junk);
        logic [31:0] hi;
        hi = junk ? ($urandom() & 32'hFFFF_FF00) : 32'h0;
        write_reg(REG_INIT_THR, thr);
        write_reg(REG_CONF_INIT, hi | ci);
        write_reg(REG_CLOSE_FRAC, hi | cf);
        write_reg(REG_AIMD_EN, hi | ae);
        write_reg(REG_CAP_FRAC, hi | cap);
        write_reg(REG_CONF_MIN, hi | cm);
        write_reg(REG_PRED_EN, hi | pe);
        write_reg(REG_PRED_VOL, hi | pv);
    endtask

    // Offer one transaction; typed rows supply their own expectation.
    task automatic send_event(logic [1:0] mode, logic [3:0] ops, bit typed, t_status_out want);
        t_status_out res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_mode = mode;
        i_op_count = ops;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_event(mode, ops, res);
        pending_results.insert(pending_results.size(), typed ? want : res);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // One power cycle: ops with some evictions, then usually a power off, and a reboot.
    task automatic power_cycle_burst();
        t_status_out none;
        int n;
        none = '{default: '0};
        n = $urandom_range(2, 18);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) send_event(EV_EVICT, 4'($urandom()), 0, none);
            else send_event(EV_MEMOPS, 4'($urandom_range(0, 15)), 0, none);
        end
        if ($urandom_range(0, 9) != 0) send_event(EV_PWROFF, 4'($urandom()), 0, none);
        send_event(EV_REBOOT, 4'($urandom()), 0, none);
    endtask

    task automatic random_phase(int items);
        t_status_out none;
        int start;
        none = '{default: '0};
        start = items_sent;
        while (items_sent - start < items) begin
            if ($urandom_range(0, 9) == 0)
                send_event(2'($urandom()), 4'($urandom()), 0, none);
            else
                power_cycle_burst();
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_status_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (o_mode_changed && o_regular_active) entries_seen++;
                if (o_gate_vetoed) vetoes_seen++;
                if (o_regular_active !== want.regular)
                    report_mismatch("regular_active", o_regular_active, want.regular);
                if (o_mode_changed !== want.changed)
                    report_mismatch("mode_changed", o_mode_changed, want.changed);
                if (o_gate_vetoed !== want.gate)
                    report_mismatch("gate_vetoed", o_gate_vetoed, want.gate);
                if (o_threshold_now !== want.thr)
                    report_mismatch("threshold_now", o_threshold_now, want.thr);
                if (o_confidence_now !== want.conf)
                    report_mismatch("confidence_now", o_confidence_now, want.conf);
                if (o_predictor_out !== want.psum)
                    report_mismatch("predictor_out", o_predictor_out, $signed(want.psum));
            end
        end
    end

    // Receiver: alternating stretches of full speed, random stalls and a fixed
    // pattern, plus one long hold-off on request.
    initial begin
        int rc;
        rc = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_request = 1'b0;
            end
            rc++;
            case ((rc / 200) % 3)
                0: i_ready = 1'b1;
                1: i_ready = ($urandom_range(0, 3) != 0);
                default: i_ready = ((rc % 7) < 4);
            endcase
        end
    end

    // Watchdog.
    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_row rows [18];
        model_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows under reset configuration.
        rows = '{
            '{EV_MEMOPS, 4'd0,  1, '{0, 0, 0, 16, 2, 0}},
            '{EV_MEMOPS, 4'd15, 1, '{0, 0, 0, 16, 2, 0}},
            '{EV_EVICT,  4'd15, 1, '{0, 0, 0, 16, 2, 0}},
            '{EV_PWROFF, 4'd0,  1, '{0, 0, 0, 16, 2, 0}},
            '{EV_REBOOT, 4'd0,  1, '{0, 0, 0, 17, 2, 0}},
            '{EV_MEMOPS, 4'd1,  1, '{1, 1, 0, 17, 2, 0}},
            '{EV_EVICT,  4'd0,  0, '{default: '0}},
            '{EV_EVICT,  4'd0,  0, '{default: '0}},
            '{EV_MEMOPS, 4'd15, 0, '{default: '0}},
            '{EV_PWROFF, 4'd0,  0, '{default: '0}},
            '{EV_PWROFF, 4'd0,  0, '{default: '0}},
            '{EV_REBOOT, 4'd15, 0, '{default: '0}},
            '{EV_REBOOT, 4'd0,  0, '{default: '0}},
            '{EV_MEMOPS, 4'd8,  0, '{default: '0}},
            '{EV_MEMOPS, 4'd7,  0, '{default: '0}},
            '{EV_EVICT,  4'd0,  0, '{default: '0}},
            '{EV_PWROFF, 4'd0,  0, '{default: '0}},
            '{EV_REBOOT, 4'd0,  0, '{default: '0}}
        };
        foreach (rows[r]) send_event(rows[r].mode, rows[r].ops, rows[r].typed, rows[r].want);
        drain();
        random_phase(150);

        // Phase with tight limits; the receiver holds off at its start.
        drain();
        write_all_regs(32'd1, 0, 255, 1, 255, 3, 1, 0, 0);
        hold_request = 1'b1;
        random_phase(200);

        // Zero threshold, volatile perceptron, no tuning.
        drain();
        write_all_regs(32'd0, 3, 0, 0, 0, 1, 1, 1, 0);
        random_phase(200);

        // Largest threshold, saturating increase.
        drain();
        write_all_regs(32'hFFFF_FFFF, 1, 128, 1, 0, 0, 0, 1, 0);
        random_phase(200);

        drain();
        write_all_regs(32'd40, 2, 40, 1, 64, 2, 1, 0, 0);
        random_phase(200);

        // Random settings with junk in the unused data bits.
        for (int p = 0; p < 2; p++) begin
            drain();
            write_all_regs($urandom_range(0, 200), $urandom_range(0, 3), $urandom_range(0, 255),
                           $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 3),
                           $urandom_range(0, 1), $urandom_range(0, 1), 1);
            random_phase(200);
        end

        drain();
        $display("Covered %0d events and %0d results over seven register settings,",
                 items_sent, results_seen);
        $display("with %0d regular-mode entries and %0d vetoed results.",
                 entries_seen, vetoes_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/icmc_pkg.sv
hw/rtl/icmc_ctrl.sv
hw/rtl/icmc_dp.sv
hw/rtl/intermittent_compression_mode_controller.sv
tb/sv/intermittent_compression_mode_controller_tb.sv
